// ----- hw/rtl/cir_short_rate_euler_step_defines.svh -----
// Assertion helpers for the checker of this block.
`ifndef CIR_SHORT_RATE_EULER_STEP_DEFINES_SVH
`define CIR_SHORT_RATE_EULER_STEP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and masked while i_rst_n is low.
`define CIR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and masked while i_rst_n is low.
`define CIR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/cir_pkg.sv -----
package cir_pkg;

    // Fixed point format and field widths.
    localparam int FRAC_BITS       = 32;
    localparam int MAX_PATH_LENGTH = 1048576;
    localparam int REG_W           = 48;
    localparam int RATE_W          = 47;
    localparam int IDX_W           = 20;
    localparam int PLEN_W          = 21;
    localparam int Z_W             = 37;
    localparam int CFG_ADDR_W      = 3;
    localparam int IN_TDATA_W      = 40;
    localparam int OUT_TDATA_W     = 72;

    // Multiplier and square root geometry.
    localparam int MUL_W    = 64;
    localparam int MUL_HALF = MUL_W / 2;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int RAD_W    = MUL_W + FRAC_BITS;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 4;
    localparam int SQ_ITERS = ROOT_W / 2;
    localparam int SQ_CNT_W = $clog2(SQ_ITERS);

    localparam logic [61:0]       SAT_BOUND = {1'b1, 61'b0};
    localparam logic [RATE_W-1:0] RATE_MAX  = {RATE_W{1'b1}};

    localparam int LAST_CAP_I = (MAX_PATH_LENGTH - 1 < (1 << IDX_W) - 1) ?
                                (MAX_PATH_LENGTH - 1) : ((1 << IDX_W) - 1);
    localparam logic [PLEN_W-1:0] LAST_CAP = PLEN_W'(LAST_CAP_I);

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_INIT_RATE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MEAN      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KAPPA     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SIGMA     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_DT        = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_PLEN      = 3'd5;

    // Register reset values.
    localparam logic [REG_W-1:0]  RST_INIT_RATE = 48'd429496730;
    localparam logic [REG_W-1:0]  RST_MEAN      = 48'd85899346;
    localparam logic [RATE_W-1:0] RST_KAPPA     = 47'd42949672960;
    localparam logic [RATE_W-1:0] RST_SIGMA     = 47'd257698038;
    localparam logic [RATE_W-1:0] RST_DT        = 47'd429497;
    localparam logic [PLEN_W-1:0] RST_PLEN      = 21'd10000;

    // Operand selection for the shared multiplier.
    typedef logic [2:0] t_mul_sel;
    localparam t_mul_sel MS_VAR   = 3'd0;
    localparam t_mul_sel MS_KDT   = 3'd1;
    localparam t_mul_sel MS_DRIFT = 3'd2;
    localparam t_mul_sel MS_SIG   = 3'd3;
    localparam t_mul_sel MS_DIFF  = 3'd4;

    typedef struct packed {
        logic     in_load;
        logic     restart;
        logic     mul_start;
        t_mul_sel mul_sel;
        logic     sqrt_start;
        logic     sum;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic root_ready;
    } t_stat;

endpackage

// ----- hw/rtl/cir_mul.sv -----
module cir_mul import cir_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MUL_W-1:0] i_a_mag,
    input  logic [MUL_W-1:0] i_b_mag,
    input  logic             i_neg,
    output logic             o_done,
    output logic [MUL_W-1:0] o_res
);

    localparam logic [2:0] PP_COUNT = 3'd4;
    localparam logic [2:0] FIN_STEP = 3'd5;
    localparam logic [PROD_W-1:0] RND_BIAS = (PROD_W'(1) << FRAC_BITS) - PROD_W'(1);

    logic              r_busy;
    logic [2:0]        r_cnt;
    logic              r_done;
    logic [MUL_W-1:0]  r_a;
    logic [MUL_W-1:0]  r_b;
    logic              r_neg;
    logic [MUL_W-1:0]  r_pp;
    logic              r_pp_vld;
    logic [1:0]        r_pp_sh;
    logic [PROD_W-1:0] r_acc;
    logic [MUL_W-1:0]  r_res;

    logic [MUL_HALF-1:0] a_chunk;
    logic [MUL_HALF-1:0] b_chunk;
    logic [MUL_W-1:0]    pp_prod;
    logic [PROD_W-1:0]   pp_shifted;
    logic [PROD_W-1:0]   quot;
    logic [61:0]         mag;
    logic [MUL_W-1:0]    mag_ext;

    assign a_chunk    = r_cnt[1] ? r_a[MUL_W-1:MUL_HALF] : r_a[MUL_HALF-1:0];
    assign b_chunk    = r_cnt[0] ? r_b[MUL_W-1:MUL_HALF] : r_b[MUL_HALF-1:0];
    assign pp_prod    = MUL_W'(a_chunk) * MUL_W'(b_chunk);
    assign pp_shifted = PROD_W'(r_pp) << {r_pp_sh, 5'b0};

    // The accumulator starts with the rounding bias for negative products,
    // so the shift below gives floor rounding of the signed product.
    assign quot    = r_acc >> FRAC_BITS;
    assign mag     = (quot > PROD_W'(SAT_BOUND)) ? SAT_BOUND : quot[61:0];
    assign mag_ext = MUL_W'(mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_done   <= 1'b0;
            r_pp_vld <= 1'b0;
        end else begin
            r_done   <= 1'b0;
            r_pp_vld <= r_busy && (r_cnt < PP_COUNT);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == FIN_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pp    <= pp_prod;
        r_pp_sh <= {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
        if (i_start) begin
            r_a   <= i_a_mag;
            r_b   <= i_b_mag;
            r_neg <= i_neg;
            r_acc <= i_neg ? RND_BIAS : '0;
        end else if (r_pp_vld) begin
            r_acc <= r_acc + pp_shifted;
        end
        if (r_busy && (r_cnt == FIN_STEP)) begin
            r_res <= r_neg ? (MUL_W'(0) - mag_ext) : mag_ext;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ----- hw/rtl/cir_sqrt.sv -----
module cir_sqrt import cir_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MUL_W-1:0]  i_val,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    logic                r_busy;
    logic [SQ_CNT_W-1:0] r_cnt;
    logic                r_done;
    logic [RAD_W-1:0]    r_rad;
    logic [REM_W-1:0]    r_rem;
    logic [ROOT_W-1:0]   r_root;

    logic [REM_W+ROOT_W-1:0] step1;
    logic [REM_W+ROOT_W-1:0] step2;

    // One restoring step: bring down two radicand bits and try a 1 digit.
    function automatic logic [REM_W+ROOT_W-1:0] sq_step(
        input logic [REM_W-1:0]  rem,
        input logic [ROOT_W-1:0] root,
        input logic [1:0]        bits
    );
        logic [REM_W-1:0]        rem_s;
        logic [REM_W-1:0]        trial;
        logic [REM_W+ROOT_W-1:0] res;
        rem_s = {rem[REM_W-3:0], bits};
        trial = REM_W'({root, 2'b01});
        if (rem_s >= trial) begin
            res = {rem_s - trial, root[ROOT_W-2:0], 1'b1};
        end else begin
            res = {rem_s, root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

    assign step1 = sq_step(r_rem, r_root, r_rad[RAD_W-1:RAD_W-2]);
    assign step2 = sq_step(step1[REM_W+ROOT_W-1:ROOT_W], step1[ROOT_W-1:0],
                           r_rad[RAD_W-3:RAD_W-4]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + SQ_CNT_W'(1);
                if (r_cnt == SQ_CNT_W'(SQ_ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= RAD_W'(i_val) << FRAC_BITS;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 4;
            r_rem  <= step2[REM_W+ROOT_W-1:ROOT_W];
            r_root <= step2[ROOT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- hw/rtl/cir_dp.sv -----
module cir_dp import cir_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [REG_W-1:0]      i_cfg_wdata,
    input  logic [Z_W-1:0]        i_z,
    output logic [RATE_W-1:0]     o_rate,
    output logic [IDX_W-1:0]      o_index,
    output logic                  o_last
);

    // Configuration registers.
    logic [REG_W-1:0]  r_init_rate;
    logic [REG_W-1:0]  r_mean;
    logic [RATE_W-1:0] r_kappa;
    logic [RATE_W-1:0] r_sigma;
    logic [RATE_W-1:0] r_dt;
    logic [PLEN_W-1:0] r_plen;

    // Path state.
    logic [REG_W-1:0] r_rate;
    logic [IDX_W-1:0] r_count;

    logic [Z_W-1:0]    r_z;
    logic [MUL_W-1:0]  r_drift;
    t_mul_sel          r_mul_sel;
    logic              r_root_ok;
    logic [RATE_W-1:0] r_res_rate;
    logic [IDX_W-1:0]  r_res_idx;
    logic              r_res_last;
    logic [RATE_W-1:0] r_out_rate;
    logic [IDX_W-1:0]  r_out_idx;
    logic              r_out_last;

    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic              mul_neg;
    logic              mul_done;
    logic [MUL_W-1:0]  mul_res;
    logic              sq_done;
    logic [ROOT_W-1:0] sq_root;

    logic [REG_W:0]    tr_diff;
    logic [REG_W:0]    tr_mag;
    logic [Z_W-1:0]    z_mag;
    logic [PLEN_W-1:0] plen_m1;
    logic [IDX_W-1:0]  cap;
    logic [IDX_W-1:0]  count_nxt;
    logic [MUL_W-1:0]  sum_full;
    logic [RATE_W-1:0] sum_clamped;
    logic [RATE_W-1:0] init_floor;

    assign tr_diff = {r_mean[REG_W-1], r_mean} - {r_rate[REG_W-1], r_rate};
    assign tr_mag  = tr_diff[REG_W] ? ((REG_W+1)'(0) - tr_diff) : tr_diff;
    assign z_mag   = r_z[Z_W-1] ? (Z_W'(0) - r_z) : r_z;

    // The previous multiplier result stays on mul_res until the next one
    // finishes, so chained products take it straight from there.
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        case (i_cmd.mul_sel)
            MS_VAR: begin
                mul_a = r_rate[REG_W-1] ? '0 : MUL_W'(r_rate[RATE_W-1:0]);
                mul_b = MUL_W'(r_dt);
            end
            MS_KDT: begin
                mul_a = MUL_W'(r_kappa);
                mul_b = MUL_W'(r_dt);
            end
            MS_DRIFT: begin
                mul_a   = mul_res;
                mul_b   = MUL_W'(tr_mag);
                mul_neg = tr_diff[REG_W];
            end
            MS_SIG: begin
                mul_a = MUL_W'(r_sigma);
                mul_b = MUL_W'(sq_root);
            end
            MS_DIFF: begin
                mul_a   = mul_res;
                mul_b   = MUL_W'(z_mag);
                mul_neg = r_z[Z_W-1];
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    cir_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a_mag (mul_a),
        .i_b_mag (mul_b),
        .i_neg   (mul_neg),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    cir_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_val   (mul_res),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // Last index of a path: path_length - 1, with zero read as one.
    assign plen_m1   = (r_plen == '0) ? '0 : (r_plen - PLEN_W'(1));
    assign cap       = (plen_m1 > LAST_CAP) ? LAST_CAP[IDX_W-1:0] : plen_m1[IDX_W-1:0];
    assign count_nxt = (r_count < cap) ? (r_count + IDX_W'(1)) : r_count;

    // The sum runs on the diffusion product in the cycle it completes.
    assign sum_full = {{(MUL_W-REG_W){r_rate[REG_W-1]}}, r_rate} + r_drift + mul_res;
    always_comb begin
        if (sum_full[MUL_W-1]) begin
            sum_clamped = '0;
        end else if (sum_full > MUL_W'(RATE_MAX)) begin
            sum_clamped = RATE_MAX;
        end else begin
            sum_clamped = sum_full[RATE_W-1:0];
        end
    end

    assign init_floor = r_init_rate[REG_W-1] ? '0 : r_init_rate[RATE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_rate <= RST_INIT_RATE;
            r_mean      <= RST_MEAN;
            r_kappa     <= RST_KAPPA;
            r_sigma     <= RST_SIGMA;
            r_dt        <= RST_DT;
            r_plen      <= RST_PLEN;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_INIT_RATE: r_init_rate <= i_cfg_wdata;
                REG_MEAN:      r_mean      <= i_cfg_wdata;
                REG_KAPPA:     r_kappa     <= i_cfg_wdata[RATE_W-1:0];
                REG_SIGMA:     r_sigma     <= i_cfg_wdata[RATE_W-1:0];
                REG_DT:        r_dt        <= i_cfg_wdata[RATE_W-1:0];
                REG_PLEN:      r_plen      <= i_cfg_wdata[PLEN_W-1:0];
                default: begin
                    r_plen <= r_plen;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate    <= '0;
            r_count   <= '0;
            r_root_ok <= 1'b0;
        end else begin
            if (i_cmd.in_load && i_cmd.restart) begin
                r_rate  <= r_init_rate;
                r_count <= '0;
            end else if (i_cmd.sum) begin
                r_rate  <= REG_W'(sum_clamped);
                r_count <= count_nxt;
            end
            if (i_cmd.sqrt_start) begin
                r_root_ok <= 1'b0;
            end else if (sq_done) begin
                r_root_ok <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_z <= i_z;
        end
        if (i_cmd.mul_start) begin
            r_mul_sel <= i_cmd.mul_sel;
        end
        if (mul_done && (r_mul_sel == MS_DRIFT)) begin
            r_drift <= mul_res;
        end
        if (i_cmd.in_load && i_cmd.restart) begin
            r_res_rate <= init_floor;
            r_res_idx  <= '0;
            r_res_last <= (cap == '0);
        end else if (i_cmd.sum) begin
            r_res_rate <= sum_clamped;
            r_res_idx  <= count_nxt;
            r_res_last <= (count_nxt == cap);
        end
        if (i_cmd.out_load) begin
            r_out_rate <= r_res_rate;
            r_out_idx  <= r_res_idx;
            r_out_last <= r_res_last;
        end
    end

    assign o_stat.mul_done   = mul_done;
    assign o_stat.root_ready = r_root_ok;
    assign o_rate  = r_out_rate;
    assign o_index = r_out_idx;
    assign o_last  = r_out_last;

endmodule

// ----- hw/rtl/cir_ctrl.sv -----
module cir_ctrl import cir_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_op,
    input  logic  i_out_ready,
    output logic  o_out_valid,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_VAR   = 3'd1;
    localparam logic [2:0] S_KDT   = 3'd2;
    localparam logic [2:0] S_DRIFT = 3'd3;
    localparam logic [2:0] S_ROOT  = 3'd4;
    localparam logic [2:0] S_SIG   = 3'd5;
    localparam logic [2:0] S_DIFF  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.in_load = 1'b1;
                    cmd.restart = i_op;
                    if (i_op) begin
                        n_state = S_OUT;
                    end else begin
                        cmd.mul_start = 1'b1;
                        cmd.mul_sel   = MS_VAR;
                        n_state       = S_VAR;
                    end
                end
            end
            S_VAR: begin
                // The square root runs beside the two drift products.
                if (i_stat.mul_done) begin
                    cmd.sqrt_start = 1'b1;
                    cmd.mul_start  = 1'b1;
                    cmd.mul_sel    = MS_KDT;
                    n_state        = S_KDT;
                end
            end
            S_KDT: begin
                if (i_stat.mul_done) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MS_DRIFT;
                    n_state       = S_DRIFT;
                end
            end
            S_DRIFT: begin
                if (i_stat.mul_done) begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if (i_stat.root_ready) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MS_SIG;
                    n_state       = S_SIG;
                end
            end
            S_SIG: begin
                if (i_stat.mul_done) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MS_DIFF;
                    n_state       = S_DIFF;
                end
            end
            S_DIFF: begin
                cmd.mul_sel = MS_DIFF;
                if (i_stat.mul_done) begin
                    cmd.sum = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = cmd.out_load || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ----- hw/rtl/cir_short_rate_euler_step.sv -----
// Channel   Direction  Ports                Contents
// s_axis    in         tdata[39:0], tuser   tdata: normal_sample; tuser: op
// m_axis    out        tdata[71:0], tlast   tdata: rate, step_index; tlast: last_of_path
// cfg       in         we, addr[2:0], wdata register write, no read-back
//
// An advance word runs the variance product, the 24-iteration square root (two root bits a
// cycle) and the two diffusion products in series, all products on one shared multiplier,
// the drift products beside the root. A restart word goes through the result register to
// the output register once that is free. One word is in work at a time; the next input
// word is taken in the cycle after the result enters the output register. Reset is
// synchronous and active low.
module cir_short_rate_euler_step import cir_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // [36:0] normal_sample
    input  logic                   i_s_axis_tuser,  // [0] op
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,  // [46:0] rate, [66:47] step_index
    output logic                   o_m_axis_tlast,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [REG_W-1:0]       i_cfg_wdata
);

    t_cmd              cmd;
    t_stat             stat;
    logic [RATE_W-1:0] out_rate;
    logic [IDX_W-1:0]  out_idx;

    cir_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_op        (i_s_axis_tuser),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    cir_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_z         (i_s_axis_tdata[Z_W-1:0]),
        .o_rate      (out_rate),
        .o_index     (out_idx),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {(OUT_TDATA_W-RATE_W-IDX_W)'(0), out_idx, out_rate};

endmodule

// ----- hw/rtl/cir_chk.sv -----
`include "cir_short_rate_euler_step_defines.svh"

module cir_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [71:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    // Only one word is worked on at a time.
    `CIR_ASSERT_NXT(a_one_in_work, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "input taken again while busy")

    // A new result is only offered after the block has been working on a word.
    `CIR_ASSERT_IMP(a_result_after_work, $rose(o_m_axis_tvalid), $past(!o_s_axis_tready), "result without work")

    // Leaving reset the block is empty and ready.
    `CIR_ASSERT_IMP(a_reset_state, !$past(i_rst_n), o_s_axis_tready && !o_m_axis_tvalid, "bad state after reset")

    // A stalled result word holds.
    `CIR_ASSERT_NXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "stalled result changed")

endmodule

bind cir_short_rate_euler_step cir_chk u_cir_chk (.*);

// ----- sim/cir_short_rate_euler_step_test.sv -----
module cir_short_rate_euler_step_test;
    import cir_pkg::*;

    typedef enum logic {
        OP_ADVANCE = 1'b0,
        OP_RESTART = 1'b1
    } t_op;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [IDX_W-1:0]  step_idx;
        logic              at_end;
    } t_rate_word;

    localparam logic [63:0]         Q_ONE         = 64'd1 << FRAC_BITS;
    localparam logic signed [63:0]  RATE_TOP      = (64'sd1 <<< RATE_W) - 64'sd1;
    localparam logic signed [127:0] PRODUCT_LIMIT = 128'sd1 <<< 61;
    localparam int                  INDEX_TOP     = (1 << IDX_W) - 1;

    localparam logic [Z_W-1:0]   Z_MAX      = {1'b0, {(Z_W-1){1'b1}}};
    localparam logic [Z_W-1:0]   Z_MIN      = {1'b1, {(Z_W-1){1'b0}}};
    localparam logic [Z_W-1:0]   Z_HALF_UP  = {2'b01, {(Z_W-2){1'b0}}};
    localparam logic [Z_W-1:0]   Z_HALF_DN  = {2'b11, {(Z_W-2){1'b0}}};
    localparam logic [REG_W-1:0] S48_MIN    = {1'b1, {(REG_W-1){1'b0}}};
    localparam logic [REG_W-1:0] S48_MAX    = {1'b0, {(REG_W-1){1'b1}}};
    localparam logic [REG_W-1:0] U47_MAX    = {{(REG_W-RATE_W){1'b0}}, {RATE_W{1'b1}}};
    localparam logic [REG_W-1:0] PLEN_TOP   = {{(REG_W-PLEN_W){1'b0}}, {PLEN_W{1'b1}}};
    localparam logic [REG_W-1:0] PLEN_LIMIT = REG_W'(MAX_PATH_LENGTH);

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;   // [36:0] normal_sample
    logic                   i_s_axis_tuser;   // [0] op
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;   // [46:0] rate, [66:47] step_index
    logic                   o_m_axis_tlast;
    logic                   i_cfg_we;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [REG_W-1:0]       i_cfg_wdata;

    // Register copies and path state of the predictor.
    logic signed [REG_W-1:0] init_rate_cfg;
    logic signed [REG_W-1:0] mean_cfg;
    logic [RATE_W-1:0]       kappa_cfg;
    logic [RATE_W-1:0]       sigma_cfg;
    logic [RATE_W-1:0]       dt_cfg;
    logic [PLEN_W-1:0]       plen_cfg;
    logic signed [63:0]      rate_state;
    logic [IDX_W-1:0]        index_state;

    t_rate_word pending_rates[$];
    int         words_sent;
    int         results_seen;
    int         mismatch_count;
    int         hold_cycles;
    bit         idling;

    cir_short_rate_euler_step i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // Exact product, floor rounding, clamped to +-2^61.
    function automatic logic signed [63:0] fixed_mul(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [127:0] wide_a;
        logic signed [127:0] wide_b;
        logic signed [127:0] q;
        wide_a = a;
        wide_b = b;
        q = (wide_a * wide_b) >>> FRAC_BITS;
        if (q > PRODUCT_LIMIT) begin
            q = PRODUCT_LIMIT;
        end else if (q < -PRODUCT_LIMIT) begin
            q = -PRODUCT_LIMIT;
        end
        return q[63:0];
    endfunction

    // floor(sqrt(v * 2^FRAC_BITS)), one root bit at a time.
    function automatic logic signed [63:0] fixed_sqrt(input logic [63:0] v);
        logic [127:0] radicand;
        logic [127:0] root;
        logic [127:0] cand;
        int           b;
        radicand = {64'd0, v} << FRAC_BITS;
        root = '0;
        for (b = 63; b >= 0; b--) begin
            cand = root | (128'd1 << b);
            if (cand * cand <= radicand) begin
                root = cand;
            end
        end
        if (root > PRODUCT_LIMIT) begin
            root = PRODUCT_LIMIT;
        end
        return root[63:0];
    endfunction

    function automatic t_rate_word euler_step(input t_op op, input logic [Z_W-1:0] sample);
        t_rate_word         word;
        logic signed [63:0] r;
        logic signed [63:0] theta;
        logic signed [63:0] kappa;
        logic signed [63:0] sigma;
        logic signed [63:0] dt;
        logic signed [63:0] z;
        logic signed [63:0] drift;
        logic signed [63:0] variance;
        logic signed [63:0] root;
        logic signed [63:0] diffusion;
        logic signed [63:0] emit;
        int                 last_idx;
        last_idx = (plen_cfg == '0) ? 0 : int'(plen_cfg) - 1;
        if (last_idx > MAX_PATH_LENGTH - 1) begin
            last_idx = MAX_PATH_LENGTH - 1;
        end
        if (last_idx > INDEX_TOP) begin
            last_idx = INDEX_TOP;
        end
        if (op == OP_RESTART) begin
            // A negative start rate is kept in the state but emitted as zero.
            rate_state = init_rate_cfg;
            index_state = '0;
            emit = (rate_state < 0) ? 64'sd0 : rate_state;
        end else begin
            r = rate_state;
            theta = mean_cfg;
            kappa = {17'd0, kappa_cfg};
            sigma = {17'd0, sigma_cfg};
            dt = {17'd0, dt_cfg};
            z = $signed(sample);
            drift = fixed_mul(fixed_mul(kappa, dt), theta - r);
            variance = fixed_mul((r < 0) ? 64'sd0 : r, dt);
            root = fixed_sqrt(variance);
            diffusion = fixed_mul(fixed_mul(sigma, root), z);
            emit = r + drift + diffusion;
            if (emit < 0) begin
                emit = 0;
            end else if (emit > RATE_TOP) begin
                emit = RATE_TOP;
            end
            rate_state = emit;
            if (index_state < last_idx) begin
                index_state++;
            end
        end
        word.rate = emit[RATE_W-1:0];
        word.step_idx = index_state;
        word.at_end = (index_state == last_idx);
        return word;
    endfunction

    function automatic logic [63:0] random_bits(input int width);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (width < 64) begin
            v &= (64'd1 << width) - 64'd1;
        end
        return v;
    endfunction

    function automatic logic [63:0] random_upto(input logic [63:0] limit);
        return random_bits(64) % (limit + 64'd1);
    endfunction

    function automatic logic [REG_W-1:0] extreme_value(input int width, input bit is_signed);
        logic [REG_W-1:0] ones;
        ones = (REG_W'(1) << width) - REG_W'(1);
        case ($urandom_range(0, 2))
            0: return is_signed ? (ones ^ (ones >> 1)) : '0;
            1: return is_signed ? (ones >> 1) : ones;
            default: return REG_W'(random_bits(width));
        endcase
    endfunction

    // Mostly draws of a few sigma, some full-width patterns and the field limits.
    function automatic logic [Z_W-1:0] random_sample();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: v = Z_MAX;
                    1: v = Z_MIN;
                    2: v = Z_HALF_UP;
                    3: v = Z_HALF_DN;
                    default: v = '0;
                endcase
            end
            1, 2: v = random_bits(Z_W);
            default: v = 64'($urandom_range(0, 5)) * Q_ONE + 64'($urandom) - 3 * Q_ONE;
        endcase
        return v[Z_W-1:0];
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatch_count++;
        $display("mismatch on %s, result %0d: got 0x%0h, expected 0x%0h",
                 what, results_seen, got, want);
    endtask

    task automatic set_register(input logic [CFG_ADDR_W-1:0] addr,
                                input logic [REG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (addr)
            REG_INIT_RATE: init_rate_cfg = value;
            REG_MEAN:      mean_cfg = value;
            REG_KAPPA:     kappa_cfg = value[RATE_W-1:0];
            REG_SIGMA:     sigma_cfg = value[RATE_W-1:0];
            REG_DT:        dt_cfg = value[RATE_W-1:0];
            REG_PLEN:      plen_cfg = value[PLEN_W-1:0];
            default: ;
        endcase
    endtask

    // Drops the input valid and waits until every predicted word has come back.
    task automatic wait_for_results();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_rates.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_word(input t_op op, input logic [Z_W-1:0] sample);
        @(negedge i_clk);
        if (idling && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= op;
        i_s_axis_tdata <= {{(IN_TDATA_W-Z_W){1'b0}}, sample};
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        pending_rates.push_back(euler_step(op, sample));
        words_sent++;
    endtask

    task automatic send_path(input int advances);
        send_word(OP_RESTART, random_sample());
        repeat (advances) send_word(OP_ADVANCE, random_sample());
    endtask

    task automatic randomize_registers();
        if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 7) == 0) begin
                set_register(REG_INIT_RATE, REG_W'(64'd0 - random_upto(Q_ONE / 10)));
            end else begin
                set_register(REG_INIT_RATE, REG_W'(random_upto(Q_ONE * 3 / 10)));
            end
            set_register(REG_MEAN, REG_W'(random_upto(Q_ONE / 4) - Q_ONE / 20));
            set_register(REG_KAPPA, REG_W'(random_upto(Q_ONE * 20)));
            set_register(REG_SIGMA, REG_W'(random_upto(Q_ONE)));
            set_register(REG_DT, REG_W'(random_upto(Q_ONE / 20)));
        end else begin
            set_register(REG_INIT_RATE, extreme_value(REG_W, 1'b1));
            set_register(REG_MEAN, extreme_value(REG_W, 1'b1));
            set_register(REG_KAPPA, extreme_value(RATE_W, 1'b0));
            set_register(REG_SIGMA, extreme_value(RATE_W, 1'b0));
            set_register(REG_DT, extreme_value(RATE_W, 1'b0));
        end
        case ($urandom_range(0, 9))
            0: set_register(REG_PLEN, REG_W'(random_bits(PLEN_W)));
            1: set_register(REG_PLEN, REG_W'($urandom_range(0, 1)));
            default: set_register(REG_PLEN, REG_W'($urandom_range(2, 24)));
        endcase
    endtask

    // Reset register values; an advance before the first restart starts from zero.
    task automatic test_fresh_state();
        send_word(OP_ADVANCE, '0);
        send_word(OP_RESTART, Z_MIN);
        send_word(OP_ADVANCE, Z_MAX);
        send_word(OP_ADVANCE, Z_MIN);
        send_word(OP_ADVANCE, '0);
        send_word(OP_ADVANCE, Z_HALF_UP);
        send_word(OP_ADVANCE, Z_HALF_DN);
    endtask

    task automatic test_negative_start();
        wait_for_results();
        set_register(REG_INIT_RATE, S48_MIN);
        set_register(REG_MEAN, S48_MAX);
        send_word(OP_RESTART, '0);
        send_word(OP_ADVANCE, Z_MAX);
        wait_for_results();
        set_register(REG_INIT_RATE, REG_W'(64'd0 - Q_ONE / 20));
        set_register(REG_MEAN, RST_MEAN);
        send_word(OP_RESTART, '0);
        send_word(OP_ADVANCE, Z_MAX);
        send_word(OP_ADVANCE, Z_MIN);
    endtask

    task automatic test_path_end();
        wait_for_results();
        set_register(REG_PLEN, REG_W'(2));
        send_word(OP_RESTART, '0);
        send_word(OP_ADVANCE, Z_HALF_UP);
        send_word(OP_ADVANCE, Z_HALF_DN);
        wait_for_results();
        // A zero length behaves as one: every word is already the last.
        set_register(REG_PLEN, REG_W'(0));
        send_word(OP_RESTART, '0);
        send_word(OP_ADVANCE, Z_MAX);
        wait_for_results();
        set_register(REG_PLEN, REG_W'(1));
        send_word(OP_RESTART, '0);
        send_word(OP_ADVANCE, Z_MIN);
    endtask

    task automatic test_saturation();
        wait_for_results();
        set_register(REG_KAPPA, U47_MAX);
        set_register(REG_DT, U47_MAX);
        set_register(REG_SIGMA, U47_MAX);
        set_register(REG_INIT_RATE, S48_MAX);
        set_register(REG_MEAN, S48_MIN);
        set_register(REG_PLEN, PLEN_TOP);
        send_word(OP_RESTART, '0);
        send_word(OP_ADVANCE, Z_MAX);
        wait_for_results();
        set_register(REG_MEAN, S48_MAX);
        set_register(REG_SIGMA, '0);
        set_register(REG_PLEN, PLEN_LIMIT);
        send_word(OP_ADVANCE, '0);
        send_word(OP_RESTART, Z_MAX);
    endtask

    // The receiver stalls long enough for the block to back up into its input.
    task automatic test_output_backpressure();
        wait_for_results();
        idling = 1'b0;
        randomize_registers();
        hold_cycles = 300;
        send_path(7);
        wait_for_results();
    endtask

    task automatic test_random_paths(input int word_goal);
        int phase_end;
        int steps;
        while (words_sent < word_goal) begin
            wait_for_results();
            idling = ($urandom_range(0, 3) != 0);
            randomize_registers();
            phase_end = words_sent + $urandom_range(30, 90);
            while (words_sent < phase_end) begin
                if ($urandom_range(0, 29) == 0) begin
                    wait_for_results();
                end
                if ($urandom_range(0, 6) == 0) begin
                    send_word(t_op'($urandom_range(0, 1)), random_sample());
                end else begin
                    // Run a little past the path end to see the index hold.
                    steps = int'(plen_cfg) + 2;
                    if (steps > 60) begin
                        steps = 60;
                    end
                    send_path($urandom_range(0, steps));
                end
            end
        end
    endtask

    task automatic test_steady_stream(input int word_goal);
        wait_for_results();
        idling = 1'b0;
        randomize_registers();
        while (words_sent < word_goal) begin
            send_path($urandom_range(0, 30));
        end
    endtask

    initial begin : drive_ready
        int stall_left;
        stall_left = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else if (idling && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 6);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_rate_word want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (pending_rates.size() == 0) begin
                note_mismatch("unexpected word", o_m_axis_tdata[63:0], '0);
            end else begin
                want = pending_rates.pop_front();
                if (o_m_axis_tdata[RATE_W-1:0] != want.rate) begin
                    note_mismatch("rate", o_m_axis_tdata[RATE_W-1:0], want.rate);
                end
                if (o_m_axis_tdata[RATE_W+IDX_W-1:RATE_W] != want.step_idx) begin
                    note_mismatch("step_index", o_m_axis_tdata[RATE_W+IDX_W-1:RATE_W],
                                  want.step_idx);
                end
                if (o_m_axis_tlast != want.at_end) begin
                    note_mismatch("last_of_path", o_m_axis_tlast, want.at_end);
                end
            end
        end
    end

    initial begin
        #12000000;
        $display("status: fail");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = REG_INIT_RATE;
        i_cfg_wdata = '0;
        init_rate_cfg = RST_INIT_RATE;
        mean_cfg = RST_MEAN;
        kappa_cfg = RST_KAPPA;
        sigma_cfg = RST_SIGMA;
        dt_cfg = RST_DT;
        plen_cfg = RST_PLEN;
        rate_state = '0;
        index_state = '0;
        words_sent = 0;
        results_seen = 0;
        mismatch_count = 0;
        hold_cycles = 0;
        idling = 1'b1;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_fresh_state();
        test_negative_start();
        test_path_end();
        test_saturation();
        test_output_backpressure();
        test_random_paths(1150);
        test_steady_stream(1260);

        wait_for_results();
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
